/* design/bjf_pkg.sv */
package bjf_pkg;

  // Command codes on in_command
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_POP    = 3'd1;
  localparam logic [2:0] CMD_DONE   = 3'd2;
  localparam logic [2:0] CMD_CLOSE  = 3'd3;
  localparam logic [2:0] CMD_CANCEL = 3'd4;

  // Status codes on out_status
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_REJ_NEWEST  = 3'd1;
  localparam logic [2:0] ST_OK_DROPPED  = 3'd2;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
  localparam logic [2:0] ST_EMPTY_RETRY = 3'd4;
  localparam logic [2:0] ST_CLOSED      = 3'd5;
  localparam logic [2:0] ST_PUSH_CLOSED = 3'd6;
  localparam logic [2:0] ST_CANCELLED   = 3'd7;

  // Overflow policy codes; the unused code behaves as block
  localparam logic [1:0] POL_BLOCK       = 2'd0;
  localparam logic [1:0] POL_DROP_NEWEST = 2'd1;
  localparam logic [1:0] POL_DROP_OLDEST = 2'd2;

  // Configuration register indexes and port widths
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_POLICY   = 1'b1;
  localparam int   CFG_DATA_W   = 5;
  localparam int   CFG_IDX_W    = 1;

  localparam int         STATUS_W   = 3;
  localparam int         CMD_W      = 3;
  localparam int         ACTIVE_W   = 8;
  localparam logic [7:0] ACTIVE_MAX = 8'd255;
  localparam int         CAP_RESET  = 16;

  // Decoded command kind passed from front to back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_DONE,
    OP_CLOSE,
    OP_CANCEL,
    OP_NOP
  } op_kind_t;

  // Configuration write beat
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

endpackage

/* design/bjf_front.sv */
module bjf_front #(
  parameter int JOB_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bjf_pkg::CMD_W-1:0]  in_command,
  input  logic [JOB_WIDTH-1:0]       in_job_word,
  input  logic                       q_full,
  output logic                       q_push,
  output bjf_pkg::op_kind_t          q_kind,
  output logic [JOB_WIDTH-1:0]       q_job
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [bjf_pkg::CMD_W-1:0]  cmd_r;
  logic [JOB_WIDTH-1:0]       job_r;
  logic                       accept;

  // Hold the beat while the op queue is full
  assign busy   = valid_r && q_full;
  assign accept = start && !busy;
  assign q_push = valid_r && !q_full;
  assign q_job  = job_r;

  // Classify the held command
  always_comb begin
    unique case (cmd_r)
      bjf_pkg::CMD_PUSH:   q_kind = bjf_pkg::OP_PUSH;
      bjf_pkg::CMD_POP:    q_kind = bjf_pkg::OP_POP;
      bjf_pkg::CMD_DONE:   q_kind = bjf_pkg::OP_DONE;
      bjf_pkg::CMD_CLOSE:  q_kind = bjf_pkg::OP_CLOSE;
      bjf_pkg::CMD_CANCEL: q_kind = bjf_pkg::OP_CANCEL;
      default:             q_kind = bjf_pkg::OP_NOP;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_command;
      job_r <= in_job_word;
    end
  end

endmodule

/* design/bjf_op_queue.sv */
module bjf_op_queue #(
  parameter int JOB_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bjf_pkg::op_kind_t     push_kind,
  input  logic [JOB_WIDTH-1:0]  push_job,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output bjf_pkg::op_kind_t     pop_kind,
  output logic [JOB_WIDTH-1:0]  pop_job
);

  // Two-entry queue between classify and execute
  bjf_pkg::op_kind_t     kind_r [2];
  logic [JOB_WIDTH-1:0]  job_r  [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            fill_r;
  logic [1:0]            fill_nxt;
  logic                  do_pop;

  assign full     = (fill_r == 2'd2);
  assign valid    = (fill_r != 2'd0);
  assign do_pop   = pop && valid;
  assign pop_kind = kind_r[rd_ptr_r];
  assign pop_job  = job_r[rd_ptr_r];

  always_comb begin
    fill_nxt = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_nxt;
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (push) begin
      kind_r[wr_ptr_r] <= push_kind;
      job_r[wr_ptr_r]  <= push_job;
    end
  end

endmodule

/* design/bjf_back.sv */
module bjf_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int JOB_WIDTH   = 32,
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bjf_pkg::cfg_wr_t              cfg,
  input  logic                          op_valid,
  input  bjf_pkg::op_kind_t             op_kind,
  input  logic [JOB_WIDTH-1:0]          op_job,
  output logic                          op_pop,
  output logic                          out_valid,
  output logic [bjf_pkg::STATUS_W-1:0]  out_status,
  output logic [JOB_WIDTH-1:0]          out_job_out,
  output logic [CW-1:0]                 out_pending_count,
  output logic [bjf_pkg::ACTIVE_W-1:0]  out_active_count,
  output logic                          out_drained,
  output logic                          out_last_result
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SW = ((IW > CW) ? IW : CW) + 1;
  localparam logic [IW-1:0] HEAD_LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CAP_RST   =
    CW'((bjf_pkg::CAP_RESET > QUEUE_DEPTH) ? QUEUE_DEPTH : bjf_pkg::CAP_RESET);

  typedef enum logic {
    S_RUN,
    S_WALK
  } state_t;

  state_t                          state_r, state_nxt;
  logic [IW-1:0]                   head_r, head_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   left_r, left_nxt;
  logic [bjf_pkg::ACTIVE_W-1:0]    active_r, active_nxt;
  logic                            closed_r, closed_nxt;
  logic [CW-1:0]                   cap_r;
  logic [1:0]                      policy_r;

  // Job store and its registered read port
  logic [JOB_WIDTH-1:0]            store [QUEUE_DEPTH];
  logic [JOB_WIDTH-1:0]            rd_data_r;
  logic                            wr_en;
  logic [IW-1:0]                   tail;
  logic [SW-1:0]                   tail_sum;

  // Result stage
  logic                            emit;
  logic                            take_job;
  logic                            last;
  logic [bjf_pkg::STATUS_W-1:0]    status;
  logic                            out_valid_r;
  logic                            use_rd_r;
  logic [bjf_pkg::STATUS_W-1:0]    status_r;
  logic [CW-1:0]                   pend_r;
  logic [bjf_pkg::ACTIVE_W-1:0]    act_r;
  logic                            drained_r;
  logic                            last_r;

  logic [IW-1:0]                   head_inc;
  logic [CW-1:0]                   cap_wr;

  assign head_inc = (head_r == HEAD_LAST) ? '0 : head_r + IW'(1);
  assign tail_sum = SW'(head_r) + SW'(count_r);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : IW'(tail_sum);
  assign op_pop   = (state_r == S_RUN);

  // Clamp a capacity write into one to the queue depth
  always_comb begin
    if (cfg.wdata == '0) begin
      cap_wr = CW'(1);
    end else if (32'(cfg.wdata) > 32'(QUEUE_DEPTH)) begin
      cap_wr = DEPTH_C;
    end else begin
      cap_wr = CW'(cfg.wdata);
    end
  end

  // Execute one op, or one step of a cancel walk
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    left_nxt   = left_r;
    active_nxt = active_r;
    closed_nxt = closed_r;
    wr_en      = 1'b0;
    emit       = 1'b0;
    take_job   = 1'b0;
    last       = 1'b1;
    status     = bjf_pkg::ST_OK;
    unique case (state_r)
      S_WALK: begin
        emit     = 1'b1;
        take_job = 1'b1;
        status   = bjf_pkg::ST_CANCELLED;
        head_nxt = head_inc;
        left_nxt = left_r - CW'(1);
        last     = (left_r == CW'(1));
        if (last) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (op_valid) begin
          emit = 1'b1;
          unique case (op_kind)
            bjf_pkg::OP_PUSH: begin
              priority if (closed_r) begin
                status = bjf_pkg::ST_PUSH_CLOSED;
              end else if (count_r < cap_r) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else if (policy_r == bjf_pkg::POL_DROP_NEWEST) begin
                status = bjf_pkg::ST_REJ_NEWEST;
              end else if (policy_r == bjf_pkg::POL_DROP_OLDEST) begin
                // Evict the head; the count stays, so the tail advances with the head
                status   = bjf_pkg::ST_OK_DROPPED;
                take_job = 1'b1;
                head_nxt = head_inc;
                wr_en    = 1'b1;
              end else begin
                status = bjf_pkg::ST_WOULD_BLOCK;
              end
            end
            bjf_pkg::OP_POP: begin
              if (count_r == '0) begin
                status = closed_r ? bjf_pkg::ST_CLOSED : bjf_pkg::ST_EMPTY_RETRY;
              end else begin
                take_job  = 1'b1;
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
                if (active_r != bjf_pkg::ACTIVE_MAX) begin
                  active_nxt = active_r + bjf_pkg::ACTIVE_W'(1);
                end
              end
            end
            bjf_pkg::OP_DONE: begin
              if (active_r != '0) begin
                active_nxt = active_r - bjf_pkg::ACTIVE_W'(1);
              end
            end
            bjf_pkg::OP_CLOSE: begin
              closed_nxt = 1'b1;
            end
            bjf_pkg::OP_CANCEL: begin
              closed_nxt = 1'b1;
              if (count_r == '0) begin
                status = bjf_pkg::ST_CLOSED;
              end else begin
                // Emit the head now, walk the rest one per cycle
                status    = bjf_pkg::ST_CANCELLED;
                take_job  = 1'b1;
                head_nxt  = head_inc;
                count_nxt = '0;
                left_nxt  = count_r - CW'(1);
                last      = (count_r == CW'(1));
                if (!last) begin
                  state_nxt = S_WALK;
                end
              end
            end
            default: begin
              status = bjf_pkg::ST_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  // Hold control state and the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      head_r      <= '0;
      count_r     <= '0;
      left_r      <= '0;
      active_r    <= '0;
      closed_r    <= 1'b0;
      cap_r       <= CAP_RST;
      policy_r    <= bjf_pkg::POL_BLOCK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= emit;
      if (cfg.we && cfg.index == bjf_pkg::REG_CAPACITY) begin
        cap_r <= cap_wr;
      end
      if (cfg.we && cfg.index == bjf_pkg::REG_POLICY) begin
        policy_r <= cfg.wdata[1:0];
      end
    end
    // Result payload, qualified by out_valid_r
    use_rd_r  <= take_job;
    status_r  <= status;
    pend_r    <= count_nxt;
    act_r     <= active_nxt;
    drained_r <= (count_nxt == '0) && (active_nxt == '0);
    last_r    <= last;
  end

  // Read the head, write the tail; a same-slot read returns the old job
  always_ff @(posedge clk) begin
    rd_data_r <= store[head_r];
    if (wr_en) begin
      store[tail] <= op_job;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_job_out       = use_rd_r ? rd_data_r : '0;
  assign out_pending_count = pend_r;
  assign out_active_count  = act_r;
  assign out_drained       = drained_r;
  assign out_last_result   = last_r;

endmodule

/* design/bounded_job_fifo_with_overflow_policy.sv */
// Channel   Handshake            Payload
// command   start / busy         in_command, in_job_word
// result    out_valid (strobe)   out_status, out_job_out, out_pending_count,
//                                out_active_count, out_drained, out_last_result
// config    cfg_we               cfg_index, cfg_wdata
//
// One command per cycle while busy is low; a cancel that finds n stored jobs holds
// the executor, one result a cycle for each job, while later commands wait in the op queue.
// When nothing waits, a command passes the front register, the op queue and the
// result stage in turn before out_valid rises.
// busy is high while the two-entry op queue between classify and execute is full and a beat waits.
// rst_n is synchronous: queue empty, open, no active jobs, capacity 16 (or QUEUE_DEPTH if smaller), block.
// The receiver cannot stall: every result stands for exactly one cycle.
module bounded_job_fifo_with_overflow_policy #(
  parameter int QUEUE_DEPTH = 16,
  parameter int JOB_WIDTH   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [bjf_pkg::CMD_W-1:0]       in_command,
  input  logic [JOB_WIDTH-1:0]            in_job_word,
  output logic                            out_valid,
  output logic [bjf_pkg::STATUS_W-1:0]    out_status,
  output logic [JOB_WIDTH-1:0]            out_job_out,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] out_pending_count,
  output logic [bjf_pkg::ACTIVE_W-1:0]    out_active_count,
  output logic                            out_drained,
  output logic                            out_last_result,
  input  logic                            cfg_we,
  input  logic [bjf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bjf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                   q_full;
  logic                   q_push;
  bjf_pkg::op_kind_t      q_push_kind;
  logic [JOB_WIDTH-1:0]   q_push_job;
  logic                   q_pop;
  logic                   q_valid;
  bjf_pkg::op_kind_t      q_pop_kind;
  logic [JOB_WIDTH-1:0]   q_pop_job;
  bjf_pkg::cfg_wr_t       cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  bjf_front #(
    .JOB_WIDTH (JOB_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_command  (in_command),
    .in_job_word (in_job_word),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_kind      (q_push_kind),
    .q_job       (q_push_job)
  );

  bjf_op_queue #(
    .JOB_WIDTH (JOB_WIDTH)
  ) u_op_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_kind (q_push_kind),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_kind  (q_pop_kind),
    .pop_job   (q_pop_job)
  );

  bjf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .JOB_WIDTH   (JOB_WIDTH),
    .CW          ($clog2(QUEUE_DEPTH + 1))
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .op_valid          (q_valid),
    .op_kind           (q_pop_kind),
    .op_job            (q_pop_job),
    .op_pop            (q_pop),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_job_out       (out_job_out),
    .out_pending_count (out_pending_count),
    .out_active_count  (out_active_count),
    .out_drained       (out_drained),
    .out_last_result   (out_last_result)
  );

endmodule
